### sv/multi_channel_message_mailbox_unit_assert.svh
// Assertion macros for the mailbox checker.
`ifndef MULTI_CHANNEL_MESSAGE_MAILBOX_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_MESSAGE_MAILBOX_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCMB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mcmb_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox package
// Shared types, codes and default sizes of the multi-channel message mailbox.
// ----------------------------------------------------------------------------
package mcmb_pkg;

    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_RING_DEPTH   = 16;
    localparam int DEF_MAX_ATOMS    = 16;

    localparam logic [1:0] PRIO_NORMAL = 2'd1;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_SEND   = 3'd2,
        OP_RECV   = 3'd3,
        OP_PEEK   = 3'd4,
        OP_BCAST  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  chan_id;
        logic [31:0] pid;
        logic [1:0]  prio;
        logic [31:0] atom_word;
        logic        atom_end;
        logic [63:0] time_now;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ret_value;
        logic [31:0] from_pid;
        logic [31:0] seq_no;
        logic [1:0]  msg_prio;
        logic [63:0] msg_time;
        logic [31:0] out_atom;
        logic        final_atom;
    } result_t;

endpackage

### sv/multi_channel_message_mailbox_unit.sv
// ----------------------------------------------------------------------------
// Multi-channel message mailbox
// Channel FIFOs of messages kept in a channel memory, a message memory and an
// atom memory, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   cmd (cmd_t)
// result    out        done per result beat   result (result_t)
//
// Create, close, errors found at accept and non-final atoms are handled in idle.
// Peek, an empty receive and a send to a full ring answer after a channel read.
// A send copies its n atoms to atom memory, one atom memory write per cycle.
// A receive gives n result beats, one atom memory read per result beat.
// A broadcast walks every created channel and copies n atoms to each delivery.
// Reset clears channel count, open flags and gather count; no clearing pass.
// The receiver cannot stall; busy holds off new commands during walks.
// ----------------------------------------------------------------------------
module multi_channel_message_mailbox_unit
    import mcmb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int MAX_ATOMS    = DEF_MAX_ATOMS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNW = $clog2(NUM_CHANNELS + 1);
    localparam int IDW = (CNW > 5) ? CNW : 5;
    localparam int HW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int KW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int NW  = $clog2(MAX_ATOMS + 1);
    localparam int SLOTS = NUM_CHANNELS * RING_DEPTH;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW  = $clog2(SLOTS * MAX_ATOMS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEEK,
        S_BC_RD,
        S_PUSH,
        S_COPY,
        S_RCV_CHK,
        S_RCV_ATOM
    } state_t;

    function automatic logic [SW-1:0] slot_of(logic [CIW-1:0] c, logic [HW-1:0] h);
        slot_of = SW'(int'(c) * RING_DEPTH + int'(h));
    endfunction

    function automatic logic [AW-1:0] atom_of(logic [SW-1:0] s, logic [KW-1:0] k);
        atom_of = AW'(int'(s) * MAX_ATOMS + int'(k));
    endfunction

    function automatic logic [HW-1:0] wrap_inc(logic [HW-1:0] p);
        wrap_inc = (p == HW'(RING_DEPTH - 1)) ? '0 : p + HW'(1);
    endfunction

    state_t                state_reg, state_next;
    logic [CNW-1:0]        total_reg, total_next;
    logic [NUM_CHANNELS-1:0] open_reg, open_next;
    logic [NW-1:0]         gcount_reg, gcount_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    logic [CIW-1:0]        tgt_reg, tgt_next;
    logic                  bc_reg, bc_next;
    logic [31:0]           pid_reg, pid_next;
    logic [1:0]            prio_reg, prio_next;
    logic [63:0]           time_reg, time_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [CNW-1:0]        got_reg, got_next;

    logic [31:0]           gather_mem [MAX_ATOMS];

    logic [31:0]           own_mem  [NUM_CHANNELS];
    logic [31:0]           sent_mem [NUM_CHANNELS];
    logic [HW-1:0]         head_mem [NUM_CHANNELS];
    logic [HW-1:0]         tail_mem [NUM_CHANNELS];
    logic [FW-1:0]         fill_mem [NUM_CHANNELS];
    logic [31:0]           own_q, sent_q;
    logic [HW-1:0]         head_q, tail_q;
    logic [FW-1:0]         fill_q;

    logic [31:0]           mpid_mem  [SLOTS];
    logic [31:0]           mseq_mem  [SLOTS];
    logic [63:0]           mtime_mem [SLOTS];
    logic [1:0]            mprio_mem [SLOTS];
    logic [NW-1:0]         mn_mem    [SLOTS];
    logic [31:0]           mpid_q, mseq_q;
    logic [63:0]           mtime_q;
    logic [1:0]            mprio_q;
    logic [NW-1:0]         mn_q;

    logic [31:0]           atom_mem [SLOTS * MAX_ATOMS];
    logic [31:0]           atom_q;

    logic                  accept;
    logic                  id_ok;
    logic [CIW-1:0]        cidx;
    logic [NW-1:0]         n_now;
    logic                  do_push;
    logic                  k_last;
    logic                  bc_last;

    logic                  ch_re, ch_we;
    logic [CIW-1:0]        ch_ra, ch_wa;
    logic [31:0]           ch_w_own, ch_w_sent;
    logic [HW-1:0]         ch_w_head, ch_w_tail;
    logic [FW-1:0]         ch_w_fill;
    logic                  m_re, m_we;
    logic [SW-1:0]         m_ra, m_wa;
    logic                  a_re, a_we;
    logic [AW-1:0]         a_ra, a_wa;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    assign id_ok = (cmd.chan_id != 5'd0) && (IDW'(cmd.chan_id) <= IDW'(total_reg));
    assign cidx  = CIW'(cmd.chan_id - 5'd1);
    assign n_now = (int'(gcount_reg) < MAX_ATOMS) ? gcount_reg + NW'(1) : gcount_reg;

    assign do_push = (int'(fill_q) < RING_DEPTH) &&
                     (!bc_reg || (open_reg[tgt_reg] && own_q != pid_reg));
    assign k_last  = (NW'(k_reg) + NW'(1) == n_reg);
    assign bc_last = (CNW'(tgt_reg) + CNW'(1) == total_reg);

    always_comb
    begin
        ch_re     = 1'b0;
        ch_ra     = cidx;
        ch_we     = 1'b0;
        ch_wa     = tgt_reg;
        ch_w_own  = own_q;
        ch_w_sent = sent_q;
        ch_w_head = head_q;
        ch_w_tail = tail_q;
        ch_w_fill = fill_q;
        m_re      = 1'b0;
        m_ra      = slot_of(tgt_reg, tail_q);
        m_we      = 1'b0;
        m_wa      = slot_of(tgt_reg, head_q);
        a_re      = 1'b0;
        a_ra      = atom_of(slot_of(tgt_reg, tail_q), '0);
        a_we      = 1'b0;
        a_wa      = atom_of(slot_reg, k_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_CREATE)
                    begin
                        ch_we     = (int'(total_reg) < NUM_CHANNELS);
                        ch_wa     = CIW'(total_reg);
                        ch_w_own  = cmd.pid;
                        ch_w_sent = '0;
                        ch_w_head = '0;
                        ch_w_tail = '0;
                        ch_w_fill = '0;
                    end
                    else if (cmd.opcode == OP_SEND)
                    begin
                        ch_re = cmd.atom_end && id_ok && open_reg[cidx];
                    end
                    else if (cmd.opcode == OP_RECV)
                    begin
                        ch_re = id_ok && open_reg[cidx];
                    end
                    else if (cmd.opcode == OP_PEEK)
                    begin
                        ch_re = id_ok;
                    end
                end
            end
            S_BC_RD:
            begin
                ch_re = 1'b1;
                ch_ra = tgt_reg;
            end
            S_PUSH:
            begin
                if (do_push)
                begin
                    ch_we     = 1'b1;
                    ch_w_sent = sent_q + 32'd1;
                    ch_w_head = wrap_inc(head_q);
                    ch_w_fill = fill_q + FW'(1);
                    m_we      = 1'b1;
                end
            end
            S_COPY:
            begin
                a_we = 1'b1;
            end
            S_RCV_CHK:
            begin
                if (fill_q != '0)
                begin
                    ch_we     = 1'b1;
                    ch_w_tail = wrap_inc(tail_q);
                    ch_w_fill = fill_q - FW'(1);
                    m_re      = 1'b1;
                    a_re      = 1'b1;
                end
            end
            S_RCV_ATOM:
            begin
                a_re = (NW'(k_reg) + NW'(1) != mn_q);
                a_ra = atom_of(slot_reg, k_reg + KW'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            own_mem[ch_wa]  <= ch_w_own;
            sent_mem[ch_wa] <= ch_w_sent;
            head_mem[ch_wa] <= ch_w_head;
            tail_mem[ch_wa] <= ch_w_tail;
            fill_mem[ch_wa] <= ch_w_fill;
        end
        if (ch_re)
        begin
            own_q  <= own_mem[ch_ra];
            sent_q <= sent_mem[ch_ra];
            head_q <= head_mem[ch_ra];
            tail_q <= tail_mem[ch_ra];
            fill_q <= fill_mem[ch_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mpid_mem[m_wa]  <= own_q;
            mseq_mem[m_wa]  <= sent_q + 32'd1;
            mtime_mem[m_wa] <= time_reg;
            mprio_mem[m_wa] <= prio_reg;
            mn_mem[m_wa]    <= n_reg;
        end
        if (m_re)
        begin
            mpid_q  <= mpid_mem[m_ra];
            mseq_q  <= mseq_mem[m_ra];
            mtime_q <= mtime_mem[m_ra];
            mprio_q <= mprio_mem[m_ra];
            mn_q    <= mn_mem[m_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            atom_mem[a_wa] <= gather_mem[k_reg];
        end
        if (a_re)
        begin
            atom_q <= atom_mem[a_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd.opcode == OP_SEND || cmd.opcode == OP_BCAST) &&
            (int'(gcount_reg) < MAX_ATOMS))
        begin
            gather_mem[gcount_reg[KW-1:0]] <= cmd.atom_word;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        open_next   = open_reg;
        gcount_next = gcount_reg;
        tgt_next    = tgt_reg;
        bc_next     = bc_reg;
        pid_next    = pid_reg;
        prio_next   = prio_reg;
        time_next   = time_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        slot_next   = slot_reg;
        got_next    = got_reg;
        done_next   = 1'b0;
        result_next = '0;
        result_next.final_atom = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pid_next  = cmd.pid;
                    prio_next = cmd.prio;
                    time_next = cmd.time_now;
                    tgt_next  = cidx;
                    k_next    = '0;
                    unique case (cmd.opcode)
                        OP_CREATE:
                        begin
                            done_next = 1'b1;
                            if (int'(total_reg) < NUM_CHANNELS)
                            begin
                                open_next[CIW'(total_reg)] = 1'b1;
                                total_next = total_reg + CNW'(1);
                                result_next.status    = ST_OK;
                                result_next.ret_value = 8'(total_reg + CNW'(1));
                            end
                            else
                            begin
                                result_next.status = ST_ERR;
                            end
                        end
                        OP_CLOSE:
                        begin
                            done_next = 1'b1;
                            if (id_ok)
                            begin
                                open_next[cidx]    = 1'b0;
                                result_next.status = ST_OK;
                            end
                            else
                            begin
                                result_next.status = ST_ERR;
                            end
                        end
                        OP_SEND, OP_BCAST:
                        begin
                            gcount_next = cmd.atom_end ? '0 : n_now;
                            n_next      = n_now;
                            bc_next     = (cmd.opcode == OP_BCAST);
                            got_next    = '0;
                            if (cmd.atom_end)
                            begin
                                if (cmd.opcode == OP_BCAST)
                                begin
                                    prio_next = PRIO_NORMAL;
                                    tgt_next  = '0;
                                    if (total_reg == '0)
                                    begin
                                        done_next          = 1'b1;
                                        result_next.status = ST_OK;
                                    end
                                    else
                                    begin
                                        state_next = S_BC_RD;
                                    end
                                end
                                else if (id_ok && open_reg[cidx])
                                begin
                                    state_next = S_PUSH;
                                end
                                else
                                begin
                                    done_next          = 1'b1;
                                    result_next.status = ST_ERR;
                                end
                            end
                        end
                        OP_RECV:
                        begin
                            if (id_ok && open_reg[cidx])
                            begin
                                state_next = S_RCV_CHK;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_ERR;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (id_ok)
                            begin
                                state_next = S_PEEK;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_ERR;
                            end
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_ERR;
                        end
                    endcase
                end
            end
            S_PEEK:
            begin
                done_next             = 1'b1;
                result_next.status    = ST_OK;
                result_next.ret_value = (int'(fill_q) > 255) ? 8'd255 : 8'(fill_q);
                state_next            = S_IDLE;
            end
            S_BC_RD:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                k_next    = '0;
                slot_next = slot_of(tgt_reg, head_q);
                if (do_push)
                begin
                    if (bc_reg)
                    begin
                        got_next = got_reg + CNW'(1);
                    end
                    state_next = S_COPY;
                end
                else if (!bc_reg)
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_ERR;
                    state_next         = S_IDLE;
                end
                else if (bc_last)
                begin
                    done_next             = 1'b1;
                    result_next.status    = ST_OK;
                    result_next.ret_value = 8'(got_reg);
                    state_next            = S_IDLE;
                end
                else
                begin
                    tgt_next   = tgt_reg + CIW'(1);
                    state_next = S_BC_RD;
                end
            end
            S_COPY:
            begin
                k_next = k_reg + KW'(1);
                if (k_last)
                begin
                    if (!bc_reg)
                    begin
                        done_next             = 1'b1;
                        result_next.status    = ST_OK;
                        result_next.ret_value = 8'(n_reg);
                        state_next            = S_IDLE;
                    end
                    else if (bc_last)
                    begin
                        done_next             = 1'b1;
                        result_next.status    = ST_OK;
                        result_next.ret_value = 8'(got_reg);
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        tgt_next   = tgt_reg + CIW'(1);
                        state_next = S_BC_RD;
                    end
                end
            end
            S_RCV_CHK:
            begin
                k_next    = '0;
                slot_next = slot_of(tgt_reg, tail_q);
                if (fill_q == '0)
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_EMPTY;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_RCV_ATOM;
                end
            end
            S_RCV_ATOM:
            begin
                n_next                 = mn_q;
                done_next              = 1'b1;
                result_next.status     = ST_OK;
                result_next.ret_value  = 8'(mn_q);
                result_next.from_pid   = mpid_q;
                result_next.seq_no     = mseq_q;
                result_next.msg_prio   = mprio_q;
                result_next.msg_time   = mtime_q;
                result_next.out_atom   = atom_q;
                result_next.final_atom = (NW'(k_reg) + NW'(1) == mn_q);
                if (NW'(k_reg) + NW'(1) == mn_q)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            open_reg   <= '0;
            gcount_reg <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            tgt_reg    <= '0;
            bc_reg     <= 1'b0;
            pid_reg    <= '0;
            prio_reg   <= '0;
            time_reg   <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            slot_reg   <= '0;
            got_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            open_reg   <= open_next;
            gcount_reg <= gcount_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            tgt_reg    <= tgt_next;
            bc_reg     <= bc_next;
            pid_reg    <= pid_next;
            prio_reg   <= prio_next;
            time_reg   <= time_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            slot_reg   <= slot_next;
            got_reg    <= got_next;
        end
    end

endmodule

### sv/mcmb_checker.sv
// ----------------------------------------------------------------------------
// Mailbox port checker
// Checks result beats and the busy handshake seen on the top level ports.
// ----------------------------------------------------------------------------
`include "multi_channel_message_mailbox_unit_assert.svh"

module mcmb_checker
    import mcmb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    `MCMB_ASSERT_NEXT(a_run_continues, done && !result.final_atom, done, "run cut short")
    `MCMB_ASSERT_NOW(a_fail_single, done && result.status != ST_OK, result.final_atom && result.ret_value == 8'd0, "bad failure beat")
    `MCMB_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start), "busy without command")

endmodule

bind multi_channel_message_mailbox_unit mcmb_checker u_mcmb_checker (.*);
